[sv/afsk_pkg.sv]
// Shared types and constants for the AFSK 1200 demodulator.
// Used by the controller, the datapath and the top level; depends on nothing.
package afsk_pkg;

	localparam int TAPS      = 8;
	localparam int TAP_IDX_W = $clog2(TAPS);
	localparam int CORRS     = 4;
	localparam int CORR_W    = $clog2(CORRS);
	localparam int SEL_W     = TAP_IDX_W + CORR_W;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 64;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_COEF_MARK_I  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_MARK_Q  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_SPACE_I = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_SPACE_Q = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DCD_INTERVAL = 3'd4;

	localparam logic [7:0]  DCD_INTERVAL_RST = 8'd120;
	localparam logic [7:0]  SAMPLE_BIAS      = 8'h80;
	localparam logic [16:0] PLL_INC          = 17'h02000;
	localparam logic [16:0] PLL_NUDGE        = 17'h01000;
	localparam logic [16:0] PLL_MID          = 17'h09000;
	localparam logic [16:0] SHIFTER_START    = 17'h10000;
	localparam logic [10:0] HIST_NEAR_MASK   = 11'h038;
	localparam logic [10:0] HIST_FAR_MASK    = 11'h7c0;
	localparam logic signed [11:0] JIT_RESTART = 12'sd2;
	localparam logic signed [11:0] JIT_MAX     = 12'sh7ff;
	localparam logic signed [11:0] JIT_MIN     = 12'sh800;

	localparam logic [SEL_W-1:0] MAC_LAST   = '1;
	localparam logic [SEL_W-1:0] DRAIN_LAST = 5'd2;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_MAC   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_UPD   = 4'b1000
	} state_t;

	typedef struct packed {
		logic             start;
		logic             issue;
		logic [SEL_W-1:0] sel;
		logic             upd;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} stat_t;

endpackage

[sv/afsk_ctrl.sv]
// Sequencer for the demodulator: accepts a sample, steps the shared MAC over
// all correlator taps, drains the pipeline and fires the state update. Uses afsk_pkg.
module afsk_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  afsk_pkg::stat_t st,
	output afsk_pkg::cmd_t  cmd
);
	import afsk_pkg::*;

	state_t            state_q, state_nxt;
	logic [SEL_W-1:0]  cnt_q, cnt_nxt;

	always_comb begin
		state_nxt = state_q;
		cnt_nxt   = '0;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.start = in_valid;
				if (in_valid) begin
					state_nxt = ST_MAC;
				end
			end
			ST_MAC: begin
				cmd.issue = 1'b1;
				cmd.sel   = cnt_q;
				cnt_nxt   = cnt_q + 1'b1;
				if (cnt_q == MAC_LAST) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (cnt_q == DRAIN_LAST) begin
					state_nxt = ST_UPD;
				end else begin
					cnt_nxt = cnt_q + 1'b1;
				end
			end
			ST_UPD: begin
				// hold until the output register can take the result
				if (st.out_free) begin
					cmd.upd   = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			cnt_q   <= cnt_nxt;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

`ifndef SYNTH
	a_start_issues_first_tap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> cmd.issue && (cmd.sel == '0))
		else $error("MAC did not start at the first tap after a transaction");
	a_mac_to_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MAC) && (cnt_q == MAC_LAST) |=> (state_q == ST_DRAIN))
		else $error("sequencer did not drain after the last tap");
	a_upd_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd |=> !in_stall)
		else $error("input still stalled after the update");
`endif

endmodule

[sv/afsk_dp.sv]
// Datapath of the demodulator: configuration registers, tap line, shared MAC
// and squarer pipeline, PLL, NRZI word packer and carrier detect. Uses afsk_pkg.
module afsk_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [afsk_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [afsk_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [7:0]                          sample,
	input  afsk_pkg::cmd_t                      cmd,
	output afsk_pkg::stat_t                     st,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                channel_bit,
	output logic                                dcd_update,
	output logic                                carrier,
	output logic                                word_valid,
	output logic [15:0]                         rx_word
);
	import afsk_pkg::*;

	// configuration
	logic [CFG_DATA_W-1:0] coef_q [CORRS];
	logic [7:0]            dcd_interval_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CORRS; i++) begin
				coef_q[i] <= '0;
			end
			dcd_interval_q <= DCD_INTERVAL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COEF_MARK_I:  coef_q[0] <= cfg_data;
				REG_COEF_MARK_Q:  coef_q[1] <= cfg_data;
				REG_COEF_SPACE_I: coef_q[2] <= cfg_data;
				REG_COEF_SPACE_Q: coef_q[3] <= cfg_data;
				REG_DCD_INTERVAL: dcd_interval_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// tap line, tap 0 newest, stored as signed offset from mid level
	logic signed [7:0] tap_q [TAPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++) begin
				tap_q[i] <= '0;
			end
		end else if (cmd.start) begin
			tap_q[0] <= sample ^ SAMPLE_BIAS;
			for (int i = 1; i < TAPS; i++) begin
				tap_q[i] <= tap_q[i-1];
			end
		end
	end

	// stage 1: one product per cycle
	logic [TAP_IDX_W-1:0] tap_sel;
	logic [CORR_W-1:0]    corr_sel;
	logic signed [7:0]    coef_b;
	logic signed [15:0]   prod_s1;
	logic                 vld_s1, first_s1, last_s1;
	logic [CORR_W-1:0]    corr_s1;

	assign tap_sel  = cmd.sel[TAP_IDX_W-1:0];
	assign corr_sel = cmd.sel[SEL_W-1:TAP_IDX_W];
	assign coef_b   = coef_q[corr_sel][{tap_sel, 3'b000} +: 8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1  <= tap_q[tap_sel] * coef_b;
		first_s1 <= (tap_sel == '0);
		last_s1  <= (tap_sel == TAP_IDX_W'(TAPS - 1));
		corr_s1  <= corr_sel;
	end

	// stage 2: correlator accumulation
	logic signed [18:0] acc_q;
	logic               done_s2;
	logic [CORR_W-1:0]  corr_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= vld_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			acc_q <= first_s1 ? 19'(prod_s1) : acc_q + 19'(prod_s1);
		end
		corr_s2 <= corr_s1;
	end

	// stage 3: floor shift by 7 and square
	logic signed [11:0] sh;
	logic signed [23:0] sq_full;
	logic [20:0]        sq_s3;
	logic               vld_s3, neg_s3;

	assign sh      = $signed(acc_q[18:7]);
	assign sq_full = sh * sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= done_s2;
		end
	end

	always_ff @(posedge clk) begin
		sq_s3  <= sq_full[20:0];
		neg_s3 <= corr_s2[CORR_W-1];
	end

	// stage 4: mark energies add, space energies subtract
	logic signed [22:0] diff_q;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			diff_q <= '0;
		end else if (vld_s3) begin
			diff_q <= neg_s3 ? diff_q - $signed({2'b00, sq_s3})
			                 : diff_q + $signed({2'b00, sq_s3});
		end
	end

	// per-sample state update
	logic [16:0]        phase_q, phase_nxt, phase_adv;
	logic               tone_q, prev_bit_q;
	logic [16:0]        shifter_q, shifter_nxt, shifter_sh;
	logic [10:0]        hist_q, hist_nxt;
	logic signed [11:0] jnow_q, jprev_q, jolder_q, jnow_nxt, jnow_tr;
	logic [7:0]         cd_q, cd_dec, cd_nxt;
	logic               tone, flip, dcd_fire, bit_tick, word_done;
	logic [2:0]         near_ones, far_ones;
	logic [10:0]        near_bits, far_bits;
	logic signed [13:0] js, csum;

	assign tone      = !diff_q[22] && (diff_q != '0);
	assign flip      = (tone != tone_q);
	assign hist_nxt  = {hist_q[9:0], flip};
	assign near_bits = hist_nxt & HIST_NEAR_MASK;
	assign far_bits  = hist_nxt & HIST_FAR_MASK;
	assign near_ones = 3'(near_bits[3]) + 3'(near_bits[4]) + 3'(near_bits[5]);
	assign far_ones  = 3'(far_bits[6]) + 3'(far_bits[7]) + 3'(far_bits[8])
	                 + 3'(far_bits[9]) + 3'(far_bits[10]);
	assign js        = 14'(jnow_q) + 14'({near_ones, 2'b00}) - 14'(far_ones);
	assign cd_dec    = cd_q - 1'b1;
	assign dcd_fire  = (cd_dec == '0);
	assign phase_adv = phase_q + PLL_INC;

	always_comb begin
		phase_nxt = phase_adv;
		jnow_tr   = jnow_q;
		if (flip) begin
			// pull the bit clock towards the transition
			if (phase_adv < PLL_MID) begin
				phase_nxt = phase_adv + PLL_NUDGE;
			end else begin
				phase_nxt = phase_adv - PLL_NUDGE;
			end
			if (js[13:11] == 3'b000 || js[13:11] == 3'b111) begin
				jnow_tr = js[11:0];
			end else begin
				jnow_tr = js[13] ? JIT_MIN : JIT_MAX;
			end
		end
	end

	assign csum     = 14'(jnow_tr) + 14'(jprev_q) + 14'(jolder_q);
	assign jnow_nxt = dcd_fire ? JIT_RESTART : jnow_tr;
	assign cd_nxt   = dcd_fire ? dcd_interval_q : cd_dec;

	assign bit_tick   = phase_nxt[16];
	assign shifter_sh = {(prev_bit_q == tone), shifter_q[16:1]};
	assign word_done  = bit_tick && shifter_sh[0];

	always_comb begin
		shifter_nxt = shifter_q;
		if (bit_tick) begin
			shifter_nxt = shifter_sh[0] ? SHIFTER_START : shifter_sh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= '0;
			tone_q     <= 1'b0;
			prev_bit_q <= 1'b0;
			shifter_q  <= SHIFTER_START;
			hist_q     <= '0;
			jnow_q     <= JIT_RESTART;
			jprev_q    <= '0;
			jolder_q   <= '0;
			cd_q       <= DCD_INTERVAL_RST;
		end else if (cmd.upd) begin
			phase_q   <= {1'b0, phase_nxt[15:0]};
			tone_q    <= tone;
			shifter_q <= shifter_nxt;
			hist_q    <= hist_nxt;
			jnow_q    <= jnow_nxt;
			cd_q      <= cd_nxt;
			if (bit_tick) begin
				prev_bit_q <= tone;
			end
			if (dcd_fire) begin
				jprev_q  <= jnow_tr;
				jolder_q <= jprev_q;
			end
		end
	end

	// output register
	logic        out_valid_q;
	logic        channel_bit_q, dcd_update_q, carrier_q, word_valid_q;
	logic [15:0] rx_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.upd) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			channel_bit_q <= tone;
			dcd_update_q  <= dcd_fire;
			carrier_q     <= dcd_fire && csum[13];
			word_valid_q  <= word_done;
			rx_word_q     <= word_done ? shifter_sh[16:1] : 16'h0000;
		end
	end

	assign st.out_free = !out_valid_q || !out_stall;
	assign out_valid   = out_valid_q;
	assign channel_bit = channel_bit_q;
	assign dcd_update  = dcd_update_q;
	assign carrier     = carrier_q;
	assign word_valid  = word_valid_q;
	assign rx_word     = rx_word_q;

`ifndef SYNTH
	a_pipe_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd |-> !vld_s1 && !done_s2 && !vld_s3)
		else $error("state update while the MAC pipeline is still busy");
	a_word_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !word_valid |-> (rx_word == 16'h0000))
		else $error("rx_word not zero without a word");
	a_carrier_qual: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !dcd_update |-> !carrier)
		else $error("carrier set without a carrier decision");
`endif

endmodule

[sv/afsk1200_demodulator.sv]
// Top level of the AFSK 1200 demodulator: joins the sequencer and the datapath.
// Depends on afsk_pkg, afsk_ctrl and afsk_dp.
//
//  channel  direction  handshake                 payload
//  input    in         in_valid / in_stall       sample
//  output   out        out_valid / out_stall     channel_bit dcd_update carrier
//                                                word_valid rx_word
//  config   in         cfg_we                    cfg_index cfg_data
//
// A sample is accepted in the idle state, steps through the single shared 8x8 multiplier
// (four correlators of eight taps), drains the accumulate/square pipeline and ends in
// an update step that loads the output register. The input stays stalled until that
// update, so a new sample is taken only after the previous result is in the output register.
// Reset clears the sequencer, configuration and demodulator state at once; there is no clearing pass.
// A stalled result holds the update step, and with it the input stall, until it is taken.
module afsk1200_demodulator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [afsk_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [afsk_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      sample,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            channel_bit,
	output logic                            dcd_update,
	output logic                            carrier,
	output logic                            word_valid,
	output logic [15:0]                     rx_word
);
	import afsk_pkg::*;

	cmd_t  cmd;
	stat_t st;

	afsk_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	afsk_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.sample      (sample),
		.cmd         (cmd),
		.st          (st),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.channel_bit (channel_bit),
		.dcd_update  (dcd_update),
		.carrier     (carrier),
		.word_valid  (word_valid),
		.rx_word     (rx_word)
	);

endmodule

[bench/afsk1200_demodulator_check.sv]
// Checker for the AFSK 1200 demodulator: watches the configuration port and both channels,
// predicts every result from its own copy of the demodulator state and compares in order.
// Depends on afsk_pkg only.
module afsk1200_demodulator_check (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [afsk_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [afsk_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  logic [7:0]                      sample,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  logic                            channel_bit,
	input  logic                            dcd_update,
	input  logic                            carrier,
	input  logic                            word_valid,
	input  logic [15:0]                     rx_word,
	output int                              failures,
	output int                              pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import afsk_pkg::*;

	typedef struct packed {
		logic        channel_bit;
		logic        dcd_update;
		logic        carrier;
		logic        word_valid;
		logic [15:0] rx_word;
	} demod_result_t;

	// configuration copy
	logic [63:0] cf_mark_i, cf_mark_q, cf_space_i, cf_space_q;
	logic [7:0]  cf_interval;

	// demodulator state copy
	logic [7:0]         taps [TAPS];
	logic [16:0]        pll_phase;
	logic               tone_state;
	logic               last_bit;
	logic [16:0]        shifter;
	logic [10:0]        history;
	logic signed [11:0] jit_now, jit_prev, jit_older;
	logic [7:0]         countdown;

	demod_result_t demod_q [$];

	function automatic int tone_energy(input logic [63:0] coefs);
		int acc;
		acc = 0;
		for (int i = 0; i < TAPS; i++)
			acc += int'($signed(taps[i])) * int'($signed(coefs[8*i +: 8]));
		acc = acc >>> 7;
		return acc * acc;
	endfunction

	function automatic int ones_in(input logic [10:0] v);
		int n;
		n = 0;
		for (int i = 0; i < 11; i++)
			n += int'(v[i]);
		return n;
	endfunction

	task automatic demodulate_sample(input logic [7:0] s, output demod_result_t r);
		int diff;
		int jsum;
		logic tone;
		r = '0;
		for (int i = TAPS - 1; i > 0; i--)
			taps[i] = taps[i-1];
		taps[0] = s - SAMPLE_BIAS;
		diff = tone_energy(cf_mark_i) + tone_energy(cf_mark_q)
			- tone_energy(cf_space_i) - tone_energy(cf_space_q);
		history = history << 1;
		pll_phase = pll_phase + PLL_INC;
		tone = (diff > 0);
		if (tone != tone_state) begin
			tone_state = tone;
			history[0] = 1'b1;
			// pull the bit clock towards the transition
			if (pll_phase < PLL_MID)
				pll_phase = pll_phase + PLL_NUDGE;
			else
				pll_phase = pll_phase - PLL_NUDGE;
			jsum = int'(jit_now) + 4 * ones_in(history & HIST_NEAR_MASK)
				- ones_in(history & HIST_FAR_MASK);
			if (jsum > int'(JIT_MAX))
				jsum = int'(JIT_MAX);
			if (jsum < int'(JIT_MIN))
				jsum = int'(JIT_MIN);
			jit_now = 12'(jsum);
		end
		countdown = countdown - 8'd1;
		if (countdown == 8'd0) begin
			r.dcd_update = 1'b1;
			r.carrier = (int'(jit_now) + int'(jit_prev) + int'(jit_older)) < 0;
			jit_older = jit_prev;
			jit_prev = jit_now;
			jit_now = JIT_RESTART;
			countdown = cf_interval;
		end
		if (pll_phase[16]) begin
			pll_phase[16] = 1'b0;
			shifter = shifter >> 1;
			if (last_bit == tone_state)
				shifter[16] = 1'b1;
			last_bit = tone_state;
			// the start marker has reached bit 0: sixteen bits are in
			if (shifter[0]) begin
				r.word_valid = 1'b1;
				r.rx_word = shifter[16:1];
				shifter = SHIFTER_START;
			end
		end
		r.channel_bit = tone_state;
	endtask

	demod_result_t want, got;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cf_mark_i = '0;
			cf_mark_q = '0;
			cf_space_i = '0;
			cf_space_q = '0;
			cf_interval = DCD_INTERVAL_RST;
			for (int i = 0; i < TAPS; i++)
				taps[i] = '0;
			pll_phase = '0;
			tone_state = 1'b0;
			last_bit = 1'b0;
			shifter = SHIFTER_START;
			history = '0;
			jit_now = JIT_RESTART;
			jit_prev = '0;
			jit_older = '0;
			countdown = DCD_INTERVAL_RST;
			demod_q.delete();
			failures = 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_COEF_MARK_I:  cf_mark_i = cfg_data;
					REG_COEF_MARK_Q:  cf_mark_q = cfg_data;
					REG_COEF_SPACE_I: cf_space_i = cfg_data;
					REG_COEF_SPACE_Q: cf_space_q = cfg_data;
					REG_DCD_INTERVAL: cf_interval = cfg_data[7:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				got = '{channel_bit, dcd_update, carrier, word_valid, rx_word};
				if (demod_q.size() == 0) begin
					if (failures < 10)
						$display({"unexpected result transaction: ",
							"bit=%0d dcd=%0d car=%0d wv=%0d word=%h"},
							got.channel_bit, got.dcd_update, got.carrier,
							got.word_valid, got.rx_word);
					failures++;
				end else begin
					want = demod_q.pop_front();
					if (got != want) begin
						if (failures < 10)
							$display({"mismatch at %0t: expected bit=%0d dcd=%0d ",
								"car=%0d wv=%0d word=%h, got bit=%0d dcd=%0d ",
								"car=%0d wv=%0d word=%h"},
								$realtime, want.channel_bit, want.dcd_update,
								want.carrier, want.word_valid, want.rx_word,
								got.channel_bit, got.dcd_update, got.carrier,
								got.word_valid, got.rx_word);
						failures++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				demodulate_sample(sample, want);
				demod_q.push_back(want);
			end
			pending <= demod_q.size();
		end
	end

endmodule

[bench/afsk1200_demodulator_test.sv]
// Stimulus and verdict for the AFSK 1200 demodulator: directed samples, then AFSK frames,
// noise and random coefficient sets. Depends on afsk_pkg, the block and its checker.
module afsk1200_demodulator_test;
	timeunit 1ns;
	timeprecision 1ps;
	import afsk_pkg::*;

	localparam int  WATCHDOG_LIMIT = 2000;
	localparam int  SETTLE_CYCLES  = 40;
	localparam real MARK_STEP      = 3.14159265358979 / 4.0;
	localparam real SPACE_STEP     = 2.0 * 3.14159265358979 * 2200.0 / 9600.0;
	localparam real TWO_PI         = 2.0 * 3.14159265358979;

	// 1200 Hz and 2200 Hz correlators at 9600 samples per second, tap 0 in the low byte
	localparam logic [63:0] MARK_COS  = 64'h5a00a681a6005a7f;
	localparam logic [63:0] MARK_SIN  = 64'ha681a6005a7f5a00;
	localparam logic [63:0] SPACE_COS = 64'h9ba64d6ecf85117f;
	localparam logic [63:0] SPACE_SIN = 64'hb35a65c08b217e00;
	// newest tap alone: the tone follows every swing away from the zero level
	localparam logic [63:0] TAP0_ONLY = 64'h000000000000007f;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [7:0]            sample;
	logic                  out_valid;
	logic                  out_stall;
	logic                  channel_bit;
	logic                  dcd_update;
	logic                  carrier;
	logic                  word_valid;
	logic [15:0]           rx_word;
	int                    failures;
	int                    pending;

	bit  no_idle;
	real tone_phase;
	bit  mark_tone;
	int  quiet_cycles = 0;

	// swings across the zero level, both extremes and the rounding edges of the shift
	logic [7:0] sent_list [12] = '{8'd0, 8'd255, 8'd128, 8'd255, 8'd128, 8'd127,
		8'd129, 8'd1, 8'd254, 8'd128, 8'd255, 8'd0};

	afsk1200_demodulator dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .sample(sample),
		.out_valid(out_valid), .out_stall(out_stall),
		.channel_bit(channel_bit), .dcd_update(dcd_update), .carrier(carrier),
		.word_valid(word_valid), .rx_word(rx_word)
	);

	afsk1200_demodulator_check chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .sample(sample),
		.out_valid(out_valid), .out_stall(out_stall),
		.channel_bit(channel_bit), .dcd_update(dcd_update), .carrier(carrier),
		.word_valid(word_valid), .rx_word(rx_word),
		.failures(failures), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// receiver: hold off each result by a drawn number of cycles, then take it
	initial begin
		int hold;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			hold = no_idle ? 0 : $urandom_range(0, 3);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	task automatic send_sample(input logic [7:0] s);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// stop sending and let every outstanding transaction come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [63:0] m_i, input logic [63:0] m_q,
			input logic [63:0] s_i, input logic [63:0] s_q, input logic [7:0] interval);
		cfg_we <= 1'b1;
		cfg_index <= REG_COEF_MARK_I;
		cfg_data <= m_i;
		@(posedge clk);
		cfg_index <= REG_COEF_MARK_Q;
		cfg_data <= m_q;
		@(posedge clk);
		cfg_index <= REG_COEF_SPACE_I;
		cfg_data <= s_i;
		@(posedge clk);
		cfg_index <= REG_COEF_SPACE_Q;
		cfg_data <= s_q;
		@(posedge clk);
		cfg_index <= REG_DCD_INTERVAL;
		cfg_data <= {$urandom, 24'($urandom), interval};
		@(posedge clk);
		// an index past the list must leave every register alone
		cfg_index <= 3'($urandom_range(5, 7));
		cfg_data <= {$urandom, $urandom};
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// flags then random octets, NRZI on a phase-continuous mark/space tone
	task automatic send_afsk_frame(input int nbytes);
		logic [7:0] octet;
		int nflags;
		int amp;
		int len;
		nflags = $urandom_range(2, 4);
		amp = $urandom_range(20, 127);
		for (int b = 0; b < nflags + nbytes; b++) begin
			octet = (b < nflags) ? 8'h7e : 8'($urandom);
			for (int k = 0; k < 8; k++) begin
				if (!octet[k])
					mark_tone = !mark_tone;
				// stretch or shorten the odd bit to make the bit clock work
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 9) : 8;
				repeat (len) begin
					tone_phase += mark_tone ? MARK_STEP : SPACE_STEP;
					if (tone_phase > TWO_PI)
						tone_phase -= TWO_PI;
					send_sample(8'(128 + $rtoi(amp * $sin(tone_phase))));
				end
			end
		end
	endtask

	task automatic send_noise(input int n);
		repeat (n) send_sample(8'($urandom));
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		sample = 8'd128;
		no_idle = 1'b0;
		tone_phase = 0.0;
		mark_tone = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset coefficients: no energy at all, the tone stays low
		send_sample(8'd0);
		send_sample(8'd255);
		send_sample(8'd128);
		drain();

		// newest tap alone, decision interval one (used once the running countdown ends): a transition on nearly every sample
		set_config(TAP0_ONLY, '0, '0, '0, 8'd1);
		foreach (sent_list[i])
			send_sample(sent_list[i]);
		drain();

		// coefficient extremes against full-scale samples
		set_config(64'h8080808080808080, 64'h7f7f7f7f7f7f7f7f, 64'h7f7f7f7f7f7f7f7f,
			64'h8080808080808080, 8'd255);
		repeat (4) begin
			send_sample(8'd0);
			send_sample(8'd255);
		end
		send_sample(8'd1);
		send_sample(8'd127);
		drain();

		// clean AFSK with the usual decision interval
		set_config(MARK_COS, MARK_SIN, SPACE_COS, SPACE_SIN, DCD_INTERVAL_RST);
		send_afsk_frame($urandom_range(1, 2));
		// hold off until everything is back, then carry on with the same setting
		drain();
		send_afsk_frame(1);
		send_noise(40);
		drain();

		// zero interval: decisions every 256 samples
		set_config(MARK_COS, MARK_SIN, SPACE_COS, SPACE_SIN, 8'd0);
		send_afsk_frame(1);
		send_noise(200);
		drain();

		// jitter stress: tone toggles at random, short intervals
		set_config(TAP0_ONLY, '0, '0, '0, 8'($urandom_range(1, 12)));
		repeat (150)
			send_sample($urandom_range(0, 1) ? 8'd128 : 8'($urandom));
		drain();

		// random coefficients, interval register at 255
		set_config({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom}, 8'd255);
		send_noise(100);
		drain();

		set_config({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom}, 8'($urandom_range(1, 255)));
		send_noise(60);
		drain();

		// mixed traffic, part of it with both sides running flat out
		set_config(MARK_COS, MARK_SIN, SPACE_COS, SPACE_SIN, 8'($urandom_range(20, 60)));
		send_afsk_frame(1);
		no_idle = 1'b1;
		send_afsk_frame(1);
		send_noise(30);
		no_idle = 1'b0;
		send_noise(30);
		drain();

		if (failures == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
